@@ hw/rtl/irpd_pkg.sv @@
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the pulse-distance IR transmitter.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int FRAME_BYTES = 4;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;
   localparam int BIT_IDX_W   = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam int DATA_W      = 32;
   localparam int TICK_W      = 12;
   localparam int PHASE_W     = 3;

   // APB register map (byte address = 4 * index)
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] REG_LEAD_IN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEADER_MARK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEADER_SPACE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_MARK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_SPACE   = 3'd6;

   // Register reset values, in 10 us ticks
   localparam logic [TICK_W-1:0] RST_LEAD_IN      = 12'd1000;
   localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 12'd900;
   localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 12'd400;
   localparam logic [TICK_W-1:0] RST_BIT_MARK     = 12'd55;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 12'd56;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 12'd112;
   localparam logic [TICK_W-1:0] RST_STOP_SPACE   = 12'd200;

   // Item kinds (req tuser)
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Sequencer phases
   localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEAD_IN      = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEADER_MARK  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEADER_SPACE = 3'd3;
   localparam logic [PHASE_W-1:0] PH_BITS         = 3'd4;
   localparam logic [PHASE_W-1:0] PH_FINAL_MARK   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_STOP_SPACE   = 3'd6;

   typedef struct packed {
      logic [TICK_W-1:0] lead_in_ticks;
      logic [TICK_W-1:0] leader_mark_ticks;
      logic [TICK_W-1:0] leader_space_ticks;
      logic [TICK_W-1:0] bit_mark_ticks;
      logic [TICK_W-1:0] zero_space_ticks;
      logic [TICK_W-1:0] one_space_ticks;
      logic [TICK_W-1:0] stop_space_ticks;
   } cfg_type;

   // mark lands in bit 0
   typedef struct packed {
      logic frame_done;
      logic busy_res;
      logic mark;
   } rsp_type;

   localparam int RSP_W       = $bits(rsp_type);
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/irpd_seq.sv @@
// ----------------------------------------------------------------------------
// irpd_seq
// Frame sequencer: phase, tick counter and bit shifter, one item per step.
// ----------------------------------------------------------------------------
module irpd_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        kind,
   input  logic [irpd_pkg::DATA_W-1:0] frame_data,
   input  irpd_pkg::cfg_type           cfg,
   output irpd_pkg::rsp_type           res
);
   import irpd_pkg::*;

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [TICK_W-1:0]    tick_count_ff, tick_count_in;
   logic [BIT_IDX_W-1:0] bit_index_ff, bit_index_in;
   logic [DATA_W-1:0]    shift_bits_ff, shift_bits_in;
   logic                 in_bit_mark_ff, in_bit_mark_in;

   logic busy_now;
   logic level_now;
   logic done;

   assign busy_now = (phase_ff >= PH_LEAD_IN) && (phase_ff <= PH_STOP_SPACE);

   always_comb begin
      case (phase_ff)
         PH_LEADER_MARK, PH_FINAL_MARK: level_now = 1'b1;
         PH_BITS:                       level_now = in_bit_mark_ff;
         default:                       level_now = 1'b0;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      tick_count_in  = tick_count_ff;
      bit_index_in   = bit_index_ff;
      shift_bits_in  = shift_bits_ff;
      in_bit_mark_in = in_bit_mark_ff;
      done           = 1'b0;
      res.mark       = level_now;

      if (kind == KIND_START) begin
         if (!busy_now) begin
            shift_bits_in  = frame_data;
            bit_index_in   = '0;
            in_bit_mark_in = 1'b0;
            phase_in       = PH_LEAD_IN;
            tick_count_in  = cfg.lead_in_ticks;
            res.mark       = 1'b0;
         end
      end else if (!busy_now) begin
         phase_in = PH_IDLE;
         res.mark = 1'b0;
      end else if (tick_count_ff > 12'd1) begin
         tick_count_in = tick_count_ff - 12'd1;
      end else begin
         // current phase runs out on this tick
         unique case (phase_ff)
            PH_LEAD_IN: begin
               phase_in      = PH_LEADER_MARK;
               tick_count_in = cfg.leader_mark_ticks;
            end
            PH_LEADER_MARK: begin
               phase_in      = PH_LEADER_SPACE;
               tick_count_in = cfg.leader_space_ticks;
            end
            PH_LEADER_SPACE: begin
               bit_index_in   = '0;
               in_bit_mark_in = 1'b1;
               phase_in       = PH_BITS;
               tick_count_in  = cfg.bit_mark_ticks;
            end
            PH_BITS: begin
               if (in_bit_mark_ff) begin
                  in_bit_mark_in = 1'b0;
                  tick_count_in  = shift_bits_ff[0] ? cfg.one_space_ticks
                                                    : cfg.zero_space_ticks;
               end else begin
                  shift_bits_in = {1'b0, shift_bits_ff[DATA_W-1:1]};
                  if (bit_index_ff == BIT_IDX_W'(FRAME_BITS - 1)) begin
                     bit_index_in  = '0;
                     phase_in      = PH_FINAL_MARK;
                     tick_count_in = cfg.bit_mark_ticks;
                  end else begin
                     bit_index_in   = bit_index_ff + 1'b1;
                     in_bit_mark_in = 1'b1;
                     tick_count_in  = cfg.bit_mark_ticks;
                  end
               end
            end
            PH_FINAL_MARK: begin
               phase_in      = PH_STOP_SPACE;
               tick_count_in = cfg.stop_space_ticks;
            end
            PH_STOP_SPACE: begin
               phase_in      = PH_IDLE;
               tick_count_in = '0;
               done          = 1'b1;
            end
            default: begin
               phase_in      = PH_IDLE;
               tick_count_in = '0;
            end
         endcase
      end

      res.busy_res   = (phase_in >= PH_LEAD_IN) && (phase_in <= PH_STOP_SPACE);
      res.frame_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_count_ff  <= '0;
         bit_index_ff   <= '0;
         shift_bits_ff  <= '0;
         in_bit_mark_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         bit_index_ff   <= bit_index_in;
         shift_bits_ff  <= shift_bits_in;
         in_bit_mark_ff <= in_bit_mark_in;
      end
   end

endmodule

@@ hw/rtl/ir_pulse_distance_transmitter_unit.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Pulse-distance IR remote transmitter: start beats load a frame while idle,
// tick beats walk the emitter through lead-in, leader, 32 data bits and stop.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -----------------------------------------
//  req      in   req_tvalid/tready    tdata = frame_data, tuser = kind
//  rsp      out  rsp_tvalid/tready    tdata = mark, busy_res, frame_done
//  csr      in   APB psel/penable     7 x 12-bit durations at 4*i, pready = 1
//
//  One beat per cycle while req_tready is high. Each accepted beat updates the
//  sequencer in the same cycle and its result word is registered in the result
//  reg, or in the skid entry while rsp stalls. A two-entry output stage (result
//  reg + skid) lets req keep flowing while rsp stalls; req_tready drops only
//  when both entries are full. Synchronous reset clears the sequencer, the
//  output stage and sets every duration register to its default.
//
module ir_pulse_distance_transmitter_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [irpd_pkg::DATA_W-1:0]       req_tdata,   // [31:0] frame_data
   input  logic                              req_tuser,   // [0] kind

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [irpd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [0] mark, [1] busy_res,
                                                          // [2] frame_done, rest 0

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [irpd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [irpd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [irpd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import irpd_pkg::*;

   // ---------------------------------------------------------------- CSRs
   cfg_type              cfg_ff;
   logic                 csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [TICK_W-1:0]    csr_rd_val;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead_in_ticks      <= RST_LEAD_IN;
         cfg_ff.leader_mark_ticks  <= RST_LEADER_MARK;
         cfg_ff.leader_space_ticks <= RST_LEADER_SPACE;
         cfg_ff.bit_mark_ticks     <= RST_BIT_MARK;
         cfg_ff.zero_space_ticks   <= RST_ZERO_SPACE;
         cfg_ff.one_space_ticks    <= RST_ONE_SPACE;
         cfg_ff.stop_space_ticks   <= RST_STOP_SPACE;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LEAD_IN:      cfg_ff.lead_in_ticks      <= csr_pwdata[TICK_W-1:0];
            REG_LEADER_MARK:  cfg_ff.leader_mark_ticks  <= csr_pwdata[TICK_W-1:0];
            REG_LEADER_SPACE: cfg_ff.leader_space_ticks <= csr_pwdata[TICK_W-1:0];
            REG_BIT_MARK:     cfg_ff.bit_mark_ticks     <= csr_pwdata[TICK_W-1:0];
            REG_ZERO_SPACE:   cfg_ff.zero_space_ticks   <= csr_pwdata[TICK_W-1:0];
            REG_ONE_SPACE:    cfg_ff.one_space_ticks    <= csr_pwdata[TICK_W-1:0];
            REG_STOP_SPACE:   cfg_ff.stop_space_ticks   <= csr_pwdata[TICK_W-1:0];
            default:          ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LEAD_IN:      csr_rd_val = cfg_ff.lead_in_ticks;
         REG_LEADER_MARK:  csr_rd_val = cfg_ff.leader_mark_ticks;
         REG_LEADER_SPACE: csr_rd_val = cfg_ff.leader_space_ticks;
         REG_BIT_MARK:     csr_rd_val = cfg_ff.bit_mark_ticks;
         REG_ZERO_SPACE:   csr_rd_val = cfg_ff.zero_space_ticks;
         REG_ONE_SPACE:    csr_rd_val = cfg_ff.one_space_ticks;
         REG_STOP_SPACE:   csr_rd_val = cfg_ff.stop_space_ticks;
         default:          csr_rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, csr_rd_val};

   // ---------------------------------------------------------- sequencer
   logic    req_beat;
   logic    rsp_beat;
   rsp_type seq_res;

   assign req_beat = req_tvalid & req_tready;
   assign rsp_beat = rsp_tvalid & rsp_tready;

   irpd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (req_beat),
      .kind       (req_tuser),
      .frame_data (req_tdata),
      .cfg        (cfg_ff),
      .res        (seq_res)
   );

   // ------------------------------------------------------ output stage
   // out_* is what rsp shows; skid_* catches a beat taken while rsp stalls.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   assign req_tready = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // no req beat possible here
         if (rsp_beat) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_beat) begin
         if (!out_valid_ff || rsp_beat) begin
            out_valid_in = 1'b1;
            out_data_in  = seq_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = seq_res;
         end
      end else if (rsp_beat) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_W){1'b0}}, out_data_ff};

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse-distance IR transmitter. Tick and start
// beats are pushed through the req stream under several duration settings.
// A cycle-free model of the sequencer predicts mark, busy and frame_done for
// every beat, and each rsp beat is compared against the oldest prediction.
// Register writes are read back over APB.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import irpd_pkg::*;

   // Index past the last register: writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int QUIET_LIMIT = 3000;   // cycles with no beat at all
   localparam int LONG_STALL  = 250;    // rsp hold-off, fills the output stage
   localparam int MAX_REPORTS = 10;

   // One req beat: kind goes on tuser, frame bytes on tdata
   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] frame;
   } ir_beat_type;

   // Sequencer state as the transmitter sees it
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TICK_W-1:0]  ticks_left;   // ticks left in phase, current included
      logic [7:0]         bit_no;
      logic [DATA_W-1:0]  shift;        // frame word, bit 0 goes out next
      logic               in_mark;      // in the mark half of a data bit
   } ir_seq_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata   = '0;   // [31:0] frame_data
   logic                   req_tuser   = 1'b0; // [0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // [0] mark, [1] busy_res, [2] frame_done
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   ir_beat_type beat_q[$];        // beats waiting for the driver
   rsp_type     expected_emitter_q[$];
   cfg_type     cfg_now;          // durations as the block should hold them
   ir_seq_type  plan_seq;         // sequencer state at the end of beat_q
   ir_seq_type  live_seq;         // sequencer state after the last accepted beat

   logic req_taken      = 1'b0;   // req beat moved at the last rising edge
   int   send_idle_pct  = 0;
   int   recv_idle_pct  = 0;
   int   stalls_asked   = 0;
   int   stalls_served  = 0;
   int   stall_left     = 0;
   int   quiet_cycles   = 0;
   int   mismatches     = 0;
   int   rsp_beats      = 0;

   ir_pulse_distance_transmitter_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Transmitter model
   // -------------------------------------------------------------------------
   function automatic logic seq_busy(input ir_seq_type s);
      return s.phase >= PH_LEAD_IN && s.phase <= PH_STOP_SPACE;
   endfunction

   // Emitter is on in both marks of the leader/final and in a bit's mark half
   function automatic logic emitter_on(input ir_seq_type s);
      case (s.phase)
         PH_LEADER_MARK, PH_FINAL_MARK: return 1'b1;
         PH_BITS:                       return s.in_mark;
         default:                       return 1'b0;
      endcase
   endfunction

   // One beat through the sequencer. Each phase length is latched on entry,
   // so a register change lands at the next phase boundary. A length of zero
   // behaves like one tick since the phase ends when ticks_left <= 1.
   function automatic rsp_type tx_sequence_step(inout ir_seq_type s, input cfg_type c,
                                                input logic kind,
                                                input logic [DATA_W-1:0] data);
      rsp_type r;
      r = '0;
      if (kind == KIND_START) begin
         // start while busy is dropped, nothing moves
         if (!seq_busy(s)) begin
            s.shift      = data;
            s.bit_no     = '0;
            s.in_mark    = 1'b0;
            s.phase      = PH_LEAD_IN;
            s.ticks_left = c.lead_in_ticks;
         end
         r.mark = emitter_on(s);
      end else if (!seq_busy(s)) begin
         s.phase = PH_IDLE;   // idle tick: all outputs low
      end else begin
         r.mark = emitter_on(s);   // level held during this tick
         if (s.ticks_left > 1) begin
            s.ticks_left = s.ticks_left - 1'b1;
         end else begin
            case (s.phase)
               PH_LEAD_IN: begin
                  s.phase      = PH_LEADER_MARK;
                  s.ticks_left = c.leader_mark_ticks;
               end
               PH_LEADER_MARK: begin
                  s.phase      = PH_LEADER_SPACE;
                  s.ticks_left = c.leader_space_ticks;
               end
               PH_LEADER_SPACE: begin
                  s.bit_no     = '0;
                  s.in_mark    = 1'b1;
                  s.phase      = PH_BITS;
                  s.ticks_left = c.bit_mark_ticks;
               end
               PH_BITS: begin
                  if (s.in_mark) begin
                     // space length encodes the bit, LSB first
                     s.in_mark    = 1'b0;
                     s.ticks_left = s.shift[0] ? c.one_space_ticks : c.zero_space_ticks;
                  end else begin
                     s.shift = s.shift >> 1;
                     if (s.bit_no + 1 >= FRAME_BITS) begin
                        s.bit_no     = '0;
                        s.phase      = PH_FINAL_MARK;
                        s.ticks_left = c.bit_mark_ticks;
                     end else begin
                        s.bit_no     = s.bit_no + 1'b1;
                        s.in_mark    = 1'b1;
                        s.ticks_left = c.bit_mark_ticks;
                     end
                  end
               end
               PH_FINAL_MARK: begin
                  s.phase      = PH_STOP_SPACE;
                  s.ticks_left = c.stop_space_ticks;
               end
               PH_STOP_SPACE: begin
                  s.phase      = PH_IDLE;
                  s.ticks_left = '0;
                  r.frame_done = 1'b1;
               end
               default: begin
                  s.phase      = PH_IDLE;
                  s.ticks_left = '0;
               end
            endcase
         end
      end
      r.busy_res = seq_busy(s);
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input longint unsigned want,
                                         input longint unsigned got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch (rsp beat %0d): expected %0h, got %0h",
                  $time, what, rsp_beats, want, got);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // Queue a beat and track where the sequencer will be once it is taken
   function automatic void queue_beat(input logic kind, input logic [DATA_W-1:0] data);
      ir_beat_type b;
      b.kind  = kind;
      b.frame = data;
      beat_q.push_back(b);
      void'(tx_sequence_step(plan_seq, cfg_now, kind, data));
   endfunction

   // Mostly well-formed frames: a start soon after idle, then ticks through
   // the frame. A few stray starts land mid-frame and get dropped. Idle ticks
   // and dropped starts are not counted.
   task automatic queue_random(input int count);
      int                n;
      logic              was_busy;
      logic [DATA_W-1:0] frame;
      n = 0;
      while (n < count) begin
         was_busy = seq_busy(plan_seq);
         case ($urandom_range(7))
            0:       frame = '0;
            1:       frame = '1;
            2:       frame = 32'hAAAA_5555;
            default: frame = $urandom();
         endcase
         if ((!was_busy && $urandom_range(3) == 0) || $urandom_range(49) == 0) begin
            queue_beat(KIND_START, frame);
            if (!was_busy)
               n++;
         end else begin
            queue_beat(KIND_TICK, $urandom());
            if (was_busy)
               n++;
         end
      end
   endtask

   task automatic queue_to_idle();
      while (seq_busy(plan_seq))
         queue_beat(KIND_TICK, $urandom());
   endtask

   // Sender holds off until every beat is out and every result is back
   task automatic wait_drained();
      while (beat_q.size() != 0 || req_tvalid || expected_emitter_q.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);   // result path is a result reg plus a skid entry
   endtask

   // APB access: setup cycle, access cycle, done at the edge with pready.
   // Reads are checked against the expected register value.
   task automatic csr_access(input logic write, input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] wdata);
      logic [TICK_W-1:0] val;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      val = wdata[TICK_W-1:0];
      case (idx)
         REG_LEAD_IN:
            if (write) cfg_now.lead_in_ticks = val; else val = cfg_now.lead_in_ticks;
         REG_LEADER_MARK:
            if (write) cfg_now.leader_mark_ticks = val; else val = cfg_now.leader_mark_ticks;
         REG_LEADER_SPACE:
            if (write) cfg_now.leader_space_ticks = val; else val = cfg_now.leader_space_ticks;
         REG_BIT_MARK:
            if (write) cfg_now.bit_mark_ticks = val; else val = cfg_now.bit_mark_ticks;
         REG_ZERO_SPACE:
            if (write) cfg_now.zero_space_ticks = val; else val = cfg_now.zero_space_ticks;
         REG_ONE_SPACE:
            if (write) cfg_now.one_space_ticks = val; else val = cfg_now.one_space_ticks;
         REG_STOP_SPACE:
            if (write) cfg_now.stop_space_ticks = val; else val = cfg_now.stop_space_ticks;
         default: ;   // unmapped: write dropped, read not checked
      endcase
      if (!write && idx <= REG_STOP_SPACE &&
          csr_prdata != {{(CSR_DATA_W-TICK_W){1'b0}}, val})
         note_mismatch("register readback", val, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_all();
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b0, i[CSR_IDX_W-1:0], '0);
   endtask

   // -------------------------------------------------------------------------
   // req driver: new beat at the falling edge once the old one has moved
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : beat_driver
      ir_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            b = beat_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= b.kind;
            req_tdata  <= b.frame;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp ready: random gaps, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_served != stalls_asked) begin
         stalls_served <= stalls_served + 1;
         stall_left    <= LONG_STALL;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predict on every req beat, check every rsp beat in order
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : emitter_check
      rsp_type want;
      rsp_type got;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_emitter_q.push_back(
               tx_sequence_step(live_seq, cfg_now, req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (expected_emitter_q.size() == 0) begin
               note_mismatch("unexpected rsp beat", 0, rsp_tdata);
            end else begin
               want = expected_emitter_q.pop_front();
               got  = rsp_tdata[RSP_W-1:0];
               if (got.mark != want.mark)
                  note_mismatch("mark", want.mark, got.mark);
               if (got.busy_res != want.busy_res)
                  note_mismatch("busy_res", want.busy_res, got.busy_res);
               if (got.frame_done != want.frame_done)
                  note_mismatch("frame_done", want.frame_done, got.frame_done);
               if (rsp_tdata[RSP_TDATA_W-1:RSP_W] != '0)
                  note_mismatch("tdata padding", 0, rsp_tdata);
            end
         end
      end
   end

   // Watchdog: any beat on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] word;
      cfg_now.lead_in_ticks      = RST_LEAD_IN;
      cfg_now.leader_mark_ticks  = RST_LEADER_MARK;
      cfg_now.leader_space_ticks = RST_LEADER_SPACE;
      cfg_now.bit_mark_ticks     = RST_BIT_MARK;
      cfg_now.zero_space_ticks   = RST_ZERO_SPACE;
      cfg_now.one_space_ticks    = RST_ONE_SPACE;
      cfg_now.stop_space_ticks   = RST_STOP_SPACE;
      plan_seq       = '0;
      plan_seq.phase = PH_IDLE;
      live_seq       = plan_seq;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults after reset
      csr_check_all();

      // Shortest durations, plus a write past the map that must not land
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b1, i[CSR_IDX_W-1:0], 32'd1);
      csr_access(1'b1, REG_UNMAPPED, 32'hFFFF_FFFF);
      csr_check_all();

      // Directed: idle tick, start with all ones, start while busy, ticks
      send_idle_pct = 10;
      recv_idle_pct = 67;
      queue_beat(KIND_TICK, 32'hFFFF_FFFF);
      queue_beat(KIND_START, 32'hFFFF_FFFF);
      queue_beat(KIND_START, 32'h0000_0000);
      for (int i = 0; i < 16; i++)
         queue_beat(KIND_TICK, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
      queue_random(300);
      wait_drained();

      // Small random durations; junk above bit 11 of pwdata must be dropped.
      // Usually lands mid-frame, so the new values take over at phase edges.
      send_idle_pct = 67;
      recv_idle_pct = 10;
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++) begin
         word        = $urandom();
         word[11:0]  = 12'($urandom_range(1, 4));
         csr_access(1'b1, i[CSR_IDX_W-1:0], word);
      end
      csr_check_all();
      queue_random(300);
      wait_drained();

      // Zero durations act as one tick; one space kept longer to tell bits apart
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b1, i[CSR_IDX_W-1:0], (i == REG_ONE_SPACE) ? 32'd2 : 32'd0);
      csr_check_all();
      queue_random(250);
      queue_to_idle();
      wait_drained();

      // Largest value everywhere reads back, then one frame with short phases
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b1, i[CSR_IDX_W-1:0], 32'hFFF);
      csr_check_all();
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b1, i[CSR_IDX_W-1:0], $urandom_range(1, 2));
      queue_beat(KIND_START, $urandom());
      queue_to_idle();
      queue_beat(KIND_TICK, $urandom());
      wait_drained();

      // Back-to-back traffic with one long rsp hold-off so the output stage
      // fills and req_tready drops while beats keep coming
      for (int i = REG_LEAD_IN; i <= REG_STOP_SPACE; i++)
         csr_access(1'b1, i[CSR_IDX_W-1:0], $urandom_range(1, 5));
      csr_check_all();
      queue_random(200);
      while (beat_q.size() > 100)
         @(posedge clock);
      stalls_asked++;
      wait_drained();

      repeat (4) @(posedge clock);
      if (expected_emitter_q.size() != 0)
         note_mismatch("results never seen", 0, expected_emitter_q.size());
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
